// ===== design/ir_pulse_distance_decoder_macros.svh =====
// Assertion macros for the IR pulse distance decoder checker.
// Each macro expects signals named clk and rst_n in the scope of use.
`ifndef IR_PULSE_DISTANCE_DECODER_MACROS_SVH
`define IR_PULSE_DISTANCE_DECODER_MACROS_SVH

// combinational invariant
`define IRPDD_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define IRPDD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define IRPDD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/irpdd_pkg.sv =====
// Package for the IR pulse distance decoder: sizes, register indexes,
// phase type and small saturating arithmetic helpers. No dependencies.
package irpdd_pkg;

  localparam int MAX_BYTES = 16;
  localparam int BYTE_AW   = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int CNT_W     = $clog2(MAX_BYTES + 1);
  localparam int TICK_W    = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_DETECT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ADJUST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_TH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STOP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FORM   = 3'd4;

  localparam logic [TICK_W-1:0] DETECT_RST = 16'd3000;
  localparam logic [TICK_W-1:0] ADJUST_RST = 16'd100;
  localparam logic [TICK_W-1:0] ONE_TH_RST = 16'd1000;
  localparam logic [TICK_W-1:0] STOP_RST   = 16'd5000;
  localparam logic [TICK_W-1:0] FORM_RST   = 16'd6000;

  localparam logic [TICK_W-1:0] TICK_MAX = '1;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_LSPACE,
    PH_DMARK,
    PH_DSPACE
  } phase_t;

  function automatic logic [TICK_W-1:0] sat_add(input logic [TICK_W-1:0] a,
                                                input logic [TICK_W-1:0] b);
    logic [TICK_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TICK_W] ? TICK_MAX : s[TICK_W-1:0];
  endfunction

  function automatic logic [TICK_W-1:0] clamp_sub(input logic [TICK_W-1:0] a,
                                                  input logic [TICK_W-1:0] b);
    return (a > b) ? (a - b) : '0;
  endfunction

  function automatic logic [TICK_W-1:0] midpoint(input logic [TICK_W-1:0] a,
                                                 input logic [TICK_W-1:0] b);
    logic [TICK_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TICK_W:1];
  endfunction

endpackage

// ===== design/ir_pulse_distance_decoder.sv =====
// IR pulse distance decoder top level: run-length measurement, bit slicing,
// byte memory and frame report sequencing. Depends on irpdd_pkg.
//
//  channel | handshake         | payload
//  --------+-------------------+------------------------------------------
//  in      | in_valid/in_stall | in_sensor_level
//  out     | out_valid/out_stall | byte, leader, count, averages, aeha, last
//  cfg     | cfg_wr_en         | cfg_index, cfg_wdata
//
// One sensor sample per cycle while decoding; counters advance per transfer.
// After a frame end, in_stall holds while the byte memory read port is primed
// and while the N result items (1..MAX_BYTES) are reported, out_stall included.
// Bytes live in a MAX_BYTES x 8 memory with a registered read port.
// Reset is synchronous, active low; the byte memory is not cleared.
module ir_pulse_distance_decoder (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_sensor_level,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [7:0]                         out_byte_value,
  output logic [3:0]                         out_byte_index,
  output logic                               out_byte_valid,
  output logic [irpdd_pkg::TICK_W-1:0]       out_leader_mark,
  output logic [irpdd_pkg::TICK_W-1:0]       out_leader_space,
  output logic [4:0]                         out_byte_count,
  output logic [irpdd_pkg::TICK_W-1:0]       out_mark_average,
  output logic [irpdd_pkg::TICK_W-1:0]       out_one_space_average,
  output logic [irpdd_pkg::TICK_W-1:0]       out_zero_space_average,
  output logic                               out_aeha_format,
  output logic                               out_last,
  input  logic                               cfg_wr_en,
  input  logic [irpdd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [irpdd_pkg::TICK_W-1:0]       cfg_wdata
);
  import irpdd_pkg::*;

  logic [TICK_W-1:0] detect_r, adjust_r, one_th_r, stop_r, form_r;

  phase_t            phase_r, phase_nxt;
  logic [TICK_W-1:0] run_r, run_nxt;
  logic [TICK_W-1:0] lmark_r, lmark_nxt;
  logic [TICK_W-1:0] lspace_r, lspace_nxt;
  logic [CNT_W-1:0]  byte_ptr_r, byte_ptr_nxt;
  logic [2:0]        bit_ptr_r, bit_ptr_nxt;
  logic [7:0]        shift_r, shift_nxt;
  logic [TICK_W-1:0] mark_max_r, mark_max_nxt, mark_min_r, mark_min_nxt;
  logic [TICK_W-1:0] one_max_r, one_max_nxt, one_min_r, one_min_nxt;
  logic [TICK_W-1:0] zero_max_r, zero_max_nxt, zero_min_r, zero_min_nxt;

  logic              emit_r, emit_nxt;
  logic              primed_r, primed_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;

  logic [7:0]        mem [MAX_BYTES];
  logic [7:0]        mem_q;
  logic              mem_we;
  logic [CNT_W-1:0]  rd_sel;

  logic              in_fire, out_fire, is_space;
  logic [TICK_W-1:0] run_inc, run_sub, run_add, one_add, inc_add;
  logic              leader_ok, bit_val, byte_done;
  logic              end_dmark, end_stop, end_full, frame_end, last_item;
  logic [31:0]       k_ext, n_ext;

  assign in_stall = emit_r;
  assign in_fire  = in_valid && !in_stall;
  assign is_space = in_sensor_level;

  assign run_inc = (run_r == TICK_MAX) ? run_r : run_r + 16'd1;
  assign run_sub = clamp_sub(run_r, adjust_r);
  assign run_add = sat_add(run_r, adjust_r);
  assign one_add = sat_add(16'd1, adjust_r);
  assign inc_add = sat_add(run_inc, adjust_r);

  assign leader_ok = run_r >= detect_r;
  assign bit_val   = run_add > one_th_r;
  assign byte_done = (phase_r == PH_DSPACE) && !is_space && (bit_ptr_r == 3'd7);
  assign end_dmark = (phase_r == PH_DMARK) && is_space && (one_add > stop_r);
  assign end_stop  = (phase_r == PH_DSPACE) && is_space && (inc_add > stop_r);
  assign end_full  = byte_done && (byte_ptr_r == CNT_W'(MAX_BYTES - 1));
  assign frame_end = in_fire && (end_dmark || end_stop || end_full);

  // phase sequencing
  always_comb begin
    phase_nxt = phase_r;
    if (in_fire) begin
      unique case (phase_r)
        PH_HUNT:   if (is_space && leader_ok) phase_nxt = PH_LSPACE;
        PH_LSPACE: if (!is_space) phase_nxt = PH_DMARK;
        PH_DMARK:  if (is_space) phase_nxt = end_dmark ? PH_HUNT : PH_DSPACE;
        PH_DSPACE: begin
          if (is_space) phase_nxt = end_stop ? PH_HUNT : PH_DSPACE;
          else          phase_nxt = end_full ? PH_HUNT : PH_DMARK;
        end
        default:   phase_nxt = PH_HUNT;
      endcase
    end
  end

  // measurement datapath and report sequencing
  always_comb begin
    run_nxt      = run_r;
    lmark_nxt    = lmark_r;
    lspace_nxt   = lspace_r;
    byte_ptr_nxt = byte_ptr_r;
    bit_ptr_nxt  = bit_ptr_r;
    shift_nxt    = shift_r;
    mark_max_nxt = mark_max_r;
    mark_min_nxt = mark_min_r;
    one_max_nxt  = one_max_r;
    one_min_nxt  = one_min_r;
    zero_max_nxt = zero_max_r;
    zero_min_nxt = zero_min_r;
    mem_we       = 1'b0;
    emit_nxt     = emit_r;
    primed_nxt   = primed_r;
    k_nxt        = k_r;
    n_nxt        = n_r;

    if (in_fire) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (!is_space)      run_nxt = run_inc;
          else if (leader_ok) begin
            lmark_nxt = run_sub;
            run_nxt   = 16'd1;
          end else            run_nxt = '0;
        end
        PH_LSPACE: begin
          if (is_space) run_nxt = run_inc;
          else begin
            lspace_nxt = run_add;
            run_nxt    = 16'd1;
          end
        end
        PH_DMARK: begin
          if (!is_space) run_nxt = run_inc;
          else begin
            if (run_sub > mark_max_r) mark_max_nxt = run_sub;
            if (run_sub < mark_min_r) mark_min_nxt = run_sub;
            run_nxt = end_dmark ? '0 : 16'd1;
          end
        end
        PH_DSPACE: begin
          if (is_space) run_nxt = end_stop ? '0 : run_inc;
          else begin
            shift_nxt   = {shift_r[6:0], bit_val};
            bit_ptr_nxt = bit_ptr_r + 3'd1;
            if (bit_val) begin
              if (run_add > one_max_r) one_max_nxt = run_add;
              if (run_add < one_min_r) one_min_nxt = run_add;
            end else begin
              if (run_add > zero_max_r) zero_max_nxt = run_add;
              if (run_add < zero_min_r) zero_min_nxt = run_add;
            end
            if (byte_done) begin
              mem_we       = 1'b1;
              byte_ptr_nxt = byte_ptr_r + 1'b1;
            end
            run_nxt = end_full ? '0 : 16'd1;
          end
        end
        default: run_nxt = '0;
      endcase
    end

    if (frame_end) begin
      byte_ptr_nxt = '0;
      bit_ptr_nxt  = '0;
      emit_nxt     = 1'b1;
      primed_nxt   = 1'b0;
      k_nxt        = '0;
      n_nxt        = end_full ? CNT_W'(MAX_BYTES) : byte_ptr_r;
    end

    if (emit_r && !primed_r) primed_nxt = 1'b1;

    if (out_fire) begin
      if (last_item) begin
        emit_nxt     = 1'b0;
        primed_nxt   = 1'b0;
        mark_max_nxt = '0;
        mark_min_nxt = TICK_MAX;
        one_max_nxt  = '0;
        one_min_nxt  = TICK_MAX;
        zero_max_nxt = '0;
        zero_min_nxt = TICK_MAX;
      end else begin
        k_nxt = k_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      detect_r <= DETECT_RST;
      adjust_r <= ADJUST_RST;
      one_th_r <= ONE_TH_RST;
      stop_r   <= STOP_RST;
      form_r   <= FORM_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_DETECT: detect_r <= cfg_wdata;
        REG_ADJUST: adjust_r <= cfg_wdata;
        REG_ONE_TH: one_th_r <= cfg_wdata;
        REG_STOP:   stop_r   <= cfg_wdata;
        REG_FORM:   form_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT;
      run_r      <= '0;
      lmark_r    <= '0;
      lspace_r   <= '0;
      byte_ptr_r <= '0;
      bit_ptr_r  <= '0;
      mark_max_r <= '0;
      mark_min_r <= TICK_MAX;
      one_max_r  <= '0;
      one_min_r  <= TICK_MAX;
      zero_max_r <= '0;
      zero_min_r <= TICK_MAX;
      emit_r     <= 1'b0;
      primed_r   <= 1'b0;
      k_r        <= '0;
      n_r        <= '0;
    end else begin
      phase_r    <= phase_nxt;
      run_r      <= run_nxt;
      lmark_r    <= lmark_nxt;
      lspace_r   <= lspace_nxt;
      byte_ptr_r <= byte_ptr_nxt;
      bit_ptr_r  <= bit_ptr_nxt;
      mark_max_r <= mark_max_nxt;
      mark_min_r <= mark_min_nxt;
      one_max_r  <= one_max_nxt;
      one_min_r  <= one_min_nxt;
      zero_max_r <= zero_max_nxt;
      zero_min_r <= zero_min_nxt;
      emit_r     <= emit_nxt;
      primed_r   <= primed_nxt;
      k_r        <= k_nxt;
      n_r        <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
  end

  // byte memory: one write port, one registered read port
  assign rd_sel = out_fire ? (k_r + 1'b1) : k_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[byte_ptr_r[BYTE_AW-1:0]] <= {shift_r[6:0], bit_val};
    mem_q <= mem[rd_sel[BYTE_AW-1:0]];
  end

  // report fields
  assign out_valid = emit_r && primed_r;
  assign out_fire  = out_valid && !out_stall;
  assign last_item = (n_r == '0) || (k_r == n_r - 1'b1);
  assign k_ext     = 32'(k_r);
  assign n_ext     = 32'(n_r);

  assign out_byte_value         = (n_r == '0) ? 8'd0 : mem_q;
  assign out_byte_index         = k_ext[3:0];
  assign out_byte_valid         = (n_r != '0);
  assign out_leader_mark        = lmark_r;
  assign out_leader_space       = lspace_r;
  assign out_byte_count         = n_ext[4:0];
  assign out_mark_average       = midpoint(mark_max_r, mark_min_r);
  assign out_one_space_average  = midpoint(one_max_r, one_min_r);
  assign out_zero_space_average = midpoint(zero_max_r, zero_min_r);
  assign out_aeha_format        = lmark_r < form_r;
  assign out_last               = last_item;

endmodule

// ===== design/irpdd_checker.sv =====
// Port-level checker for the IR pulse distance decoder, bound to the top.
// Depends on ir_pulse_distance_decoder_macros.svh.
`include "ir_pulse_distance_decoder_macros.svh"

module irpdd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte_value,
  input logic [3:0] out_byte_index,
  input logic       out_byte_valid,
  input logic [4:0] out_byte_count,
  input logic       out_last
);

  `IRPDD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte_value) && $stable(out_byte_index), "stalled result changed")
  `IRPDD_ASSERT_IMPL(a_in_held, out_valid, in_stall, "sample taken during frame report")
  `IRPDD_ASSERT_NEXT(a_gap_after_last, out_valid && out_last && !out_stall, !out_valid, "result after final transfer")
  `IRPDD_ASSERT_IMPL(a_empty_frame, out_valid && !out_byte_valid, out_last && (out_byte_count == 5'd0), "empty frame report malformed")
  `IRPDD_ASSERT_IMPL(a_index_range, out_valid && out_byte_valid, {1'b0, out_byte_index} < out_byte_count, "byte index beyond count")

endmodule

bind ir_pulse_distance_decoder irpdd_checker u_irpdd_checker (.*);

// ===== tb/sv/ir_frame_check.sv =====
`timescale 1ns / 1ps
// Frame checker for the IR pulse distance decoder: follows sample, config and
// result transfers, predicts every frame report and compares it field by field.
// Depends on irpdd_pkg.
module ir_frame_check (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic                            in_sensor_level,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [7:0]                      out_byte_value,
  input  logic [3:0]                      out_byte_index,
  input  logic                            out_byte_valid,
  input  logic [irpdd_pkg::TICK_W-1:0]    out_leader_mark,
  input  logic [irpdd_pkg::TICK_W-1:0]    out_leader_space,
  input  logic [4:0]                      out_byte_count,
  input  logic [irpdd_pkg::TICK_W-1:0]    out_mark_average,
  input  logic [irpdd_pkg::TICK_W-1:0]    out_one_space_average,
  input  logic [irpdd_pkg::TICK_W-1:0]    out_zero_space_average,
  input  logic                            out_aeha_format,
  input  logic                            out_last,
  input  logic                            cfg_wr_en,
  input  logic [irpdd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [irpdd_pkg::TICK_W-1:0]    cfg_wdata,
  output int                              fail_count,
  output int                              pending,
  output int                              reports_seen
);
  import irpdd_pkg::*;

  typedef struct packed {
    logic [7:0]  byte_value;
    logic [3:0]  byte_index;
    logic        byte_valid;
    logic [15:0] leader_mark;
    logic [15:0] leader_space;
    logic [4:0]  byte_count;
    logic [15:0] mark_avg;
    logic [15:0] one_avg;
    logic [15:0] zero_avg;
    logic        aeha;
    logic        last;
  } report_t;

  report_t frame_reports[$];

  logic [15:0] detect_th, adjust, one_th, stop_th, form_th;
  phase_t      rx_phase;
  logic [15:0] run_len, lead_mark, lead_space, data_mark;
  logic [7:0]  byte_mem[MAX_BYTES];
  int          byte_ptr, bit_ptr;
  logic [15:0] mk_max, mk_min, one_max, one_min, zro_max, zro_min;

  function automatic logic [15:0] add_sat(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  function automatic logic [15:0] sub_floor(input logic [15:0] a, input logic [15:0] b);
    return (a > b) ? a - b : 16'd0;
  endfunction

  function automatic logic [15:0] mid(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16:1];
  endfunction

  function automatic string show(input report_t r);
    return $sformatf("byte=%h idx=%0d bv=%0d lm=%0d ls=%0d cnt=%0d mavg=%0d oavg=%0d zavg=%0d aeha=%0d last=%0d",
                     r.byte_value, r.byte_index, r.byte_valid, r.leader_mark, r.leader_space,
                     r.byte_count, r.mark_avg, r.one_avg, r.zero_avg, r.aeha, r.last);
  endfunction

  task automatic track(input logic [15:0] v, inout logic [15:0] hi, inout logic [15:0] lo);
    if (v > hi) hi = v;
    if (v < lo) lo = v;
  endtask

  task automatic clear_frame();
    rx_phase = PH_HUNT;
    run_len  = '0;
    byte_ptr = 0;
    bit_ptr  = 0;
    mk_max = '0;  mk_min = '1;
    one_max = '0; one_min = '1;
    zro_max = '0; zro_min = '1;
  endtask

  task automatic clear_model();
    detect_th  = DETECT_RST;
    adjust     = ADJUST_RST;
    one_th     = ONE_TH_RST;
    stop_th    = STOP_RST;
    form_th    = FORM_RST;
    lead_mark  = '0;
    lead_space = '0;
    data_mark  = '0;
    foreach (byte_mem[i]) byte_mem[i] = '0;
    clear_frame();
    frame_reports.delete();
  endtask

  // one report per complete byte, or a single empty one
  task automatic emit_frame_reports();
    report_t r;
    int      cnt;
    cnt = (byte_ptr == 0) ? 1 : byte_ptr;
    for (int k = 0; k < cnt; k++) begin
      r.byte_value   = (byte_ptr != 0) ? byte_mem[k % MAX_BYTES] : 8'd0;
      r.byte_index   = (byte_ptr != 0) ? k[3:0] : 4'd0;
      r.byte_valid   = (byte_ptr != 0);
      r.leader_mark  = lead_mark;
      r.leader_space = lead_space;
      r.byte_count   = byte_ptr[4:0];
      r.mark_avg     = mid(mk_max, mk_min);
      r.one_avg      = mid(one_max, one_min);
      r.zero_avg     = mid(zro_max, zro_min);
      r.aeha         = (lead_mark < form_th);
      r.last         = (k + 1 == cnt);
      frame_reports.push_back(r);
    end
    clear_frame();
  endtask

  task automatic decode_tick(input logic lvl);
    logic [15:0] sp;
    logic        bit_v;
    case (rx_phase)
      PH_HUNT: begin
        if (!lvl) begin
          run_len = add_sat(run_len, 16'd1);
        end else if (run_len >= detect_th) begin
          lead_mark = sub_floor(run_len, adjust);
          run_len   = 16'd1;
          rx_phase  = PH_LSPACE;
        end else begin
          run_len = '0;
        end
      end
      PH_LSPACE: begin
        if (lvl) begin
          run_len = add_sat(run_len, 16'd1);
        end else begin
          lead_space = add_sat(run_len, adjust);
          run_len    = 16'd1;
          rx_phase   = PH_DMARK;
        end
      end
      PH_DMARK: begin
        if (!lvl) begin
          run_len = add_sat(run_len, 16'd1);
        end else begin
          data_mark = sub_floor(run_len, adjust);
          track(data_mark, mk_max, mk_min);
          run_len  = 16'd1;
          rx_phase = PH_DSPACE;
          if (add_sat(run_len, adjust) > stop_th) emit_frame_reports();
        end
      end
      default: begin
        if (lvl) begin
          run_len = add_sat(run_len, 16'd1);
          if (add_sat(run_len, adjust) > stop_th) emit_frame_reports();
        end else begin
          sp    = add_sat(run_len, adjust);
          bit_v = (sp > one_th);
          byte_mem[byte_ptr % MAX_BYTES] = {byte_mem[byte_ptr % MAX_BYTES][6:0], bit_v};
          if (bit_v) track(sp, one_max, one_min);
          else track(sp, zro_max, zro_min);
          bit_ptr++;
          if (bit_ptr == 8) begin
            bit_ptr = 0;
            byte_ptr++;
          end
          // store full: the closing mark ends the frame
          if (byte_ptr >= MAX_BYTES) begin
            emit_frame_reports();
          end else begin
            run_len  = 16'd1;
            rx_phase = PH_DMARK;
          end
        end
      end
    endcase
  endtask

  task automatic check_report();
    report_t got, want;
    got = {out_byte_value, out_byte_index, out_byte_valid, out_leader_mark, out_leader_space,
           out_byte_count, out_mark_average, out_one_space_average, out_zero_space_average,
           out_aeha_format, out_last};
    reports_seen++;
    if (frame_reports.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) $display("ERROR unexpected report: %s", show(got));
    end else begin
      want = frame_reports.pop_front();
      if (got !== want) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("ERROR report %0d expected: %s", reports_seen, show(want));
          $display("ERROR report %0d actual:   %s", reports_seen, show(got));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_model();
    end else begin
      if (out_valid && !out_stall) check_report();
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_DETECT: detect_th = cfg_wdata;
          REG_ADJUST: adjust    = cfg_wdata;
          REG_ONE_TH: one_th    = cfg_wdata;
          REG_STOP:   stop_th   = cfg_wdata;
          REG_FORM:   form_th   = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) decode_tick(in_sensor_level);
    end
    pending = frame_reports.size();
  end

endmodule

// ===== tb/sv/tb_ir_pulse_distance_decoder.sv =====
`timescale 1ns / 1ps
// Top of the IR pulse distance decoder bench: shapes remote frames and noise as
// sensor samples, sweeps register settings, stalls results and gives the verdict.
// Depends on irpdd_pkg, ir_pulse_distance_decoder and ir_frame_check.
module tb_ir_pulse_distance_decoder;
  import irpdd_pkg::*;

  localparam int RUN_LIMIT      = 200000;
  localparam int RANDOM_SAMPLES = 120;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_sensor_level = 1'b1;
  logic                 out_stall = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TICK_W-1:0]    cfg_wdata = '0;

  logic                 in_stall, out_valid;
  logic [7:0]           out_byte_value;
  logic [3:0]           out_byte_index;
  logic                 out_byte_valid;
  logic [TICK_W-1:0]    out_leader_mark, out_leader_space;
  logic [4:0]           out_byte_count;
  logic [TICK_W-1:0]    out_mark_average, out_one_space_average, out_zero_space_average;
  logic                 out_aeha_format, out_last;

  int fail_count, pending, reports_seen;
  int cycle_count = 0;
  int sample_count = 0;
  int stall_left = 0, open_left = 0, stall_pick;

  // register values in force, used to shape frames
  int   detect_v, adjust_v, one_v, stop_v;
  int   mark_hi, space_span;
  bit   in_quiet;
  logic [7:0] frame_bytes[MAX_BYTES];

  ir_pulse_distance_decoder dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_sensor_level(in_sensor_level),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_byte_value(out_byte_value), .out_byte_index(out_byte_index),
    .out_byte_valid(out_byte_valid), .out_leader_mark(out_leader_mark),
    .out_leader_space(out_leader_space), .out_byte_count(out_byte_count),
    .out_mark_average(out_mark_average), .out_one_space_average(out_one_space_average),
    .out_zero_space_average(out_zero_space_average), .out_aeha_format(out_aeha_format),
    .out_last(out_last),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  ir_frame_check u_frame_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_sensor_level(in_sensor_level),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_byte_value(out_byte_value), .out_byte_index(out_byte_index),
    .out_byte_valid(out_byte_valid), .out_leader_mark(out_leader_mark),
    .out_leader_space(out_leader_space), .out_byte_count(out_byte_count),
    .out_mark_average(out_mark_average), .out_one_space_average(out_one_space_average),
    .out_zero_space_average(out_zero_space_average), .out_aeha_format(out_aeha_format),
    .out_last(out_last),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending), .reports_seen(reports_seen)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side back-pressure: short stalls mostly, some long, some open stretches
  always @(negedge clk) begin
    if (stall_left == 0 && open_left == 0) begin
      stall_pick = $urandom_range(0, 99);
      stall_left = (stall_pick < 60) ? $urandom_range(1, 2) :
                   (stall_pick < 90) ? $urandom_range(3, 6) : $urandom_range(10, 40);
      open_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200) : $urandom_range(0, 8);
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      open_left--;
      out_stall <= 1'b0;
    end
  end

  function automatic int in_gap();
    int r;
    if (in_quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // called and returns at a falling edge
  task automatic put_sample(input logic lvl);
    int gap;
    gap = in_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_sensor_level <= lvl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sample_count++;
  endtask

  task automatic put_run(input logic lvl, input int len);
    repeat (len) put_sample(lvl);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  task automatic set_regs(input int det, input int adj, input int one, input int stp,
                          input int frm);
    logic [CFG_IDX_W-1:0] spare;
    spare = CFG_IDX_W'(REG_FORM + 1 + $urandom_range(0, 2));
    write_reg(REG_DETECT, det[15:0]);
    write_reg(REG_ADJUST, adj[15:0]);
    write_reg(REG_ONE_TH, one[15:0]);
    write_reg(REG_STOP, stp[15:0]);
    write_reg(REG_FORM, frm[15:0]);
    // unused index, must be ignored
    write_reg(spare, TICK_W'($urandom));
    cfg_wr_en <= 1'b0;
    @(negedge clk);
    detect_v = det;
    adjust_v = adj;
    one_v    = one;
    stop_v   = stp;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic int mark_len();
    return $urandom_range(1, mark_hi);
  endfunction

  // data space for one bit, biased toward the decision and stop edges
  function automatic int space_len(input logic b);
    int zhi, dmax, lo, hi;
    dmax = stop_v - adjust_v;
    zhi  = one_v - adjust_v;
    if (zhi > dmax) zhi = dmax;
    if (b) begin
      lo = (zhi < 0 ? 0 : zhi) + 1;
      hi = dmax;
    end else begin
      lo = 1;
      hi = zhi;
    end
    if (hi < lo) begin
      lo = 1;
      hi = (dmax < 1) ? 1 : dmax;
    end
    if (hi > lo + space_span) hi = lo + space_span;
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? lo : hi;
    return $urandom_range(lo, hi);
  endfunction

  function automatic int stop_len();
    int dmax;
    dmax = stop_v - adjust_v;
    return (dmax < 1) ? 1 : dmax + 1;
  endfunction

  task automatic send_frame(input int lead_mark, input int lead_space, input int nbytes,
                            input int tail_bits);
    int   nbits;
    logic b;
    nbits = nbytes * 8 + tail_bits;
    put_run(1'b0, lead_mark);
    put_run(1'b1, lead_space);
    for (int i = 0; i < nbits; i++) begin
      if (i < nbytes * 8) b = frame_bytes[i / 8][7 - (i % 8)];
      else b = $urandom_range(0, 1);
      put_run(1'b0, mark_len());
      put_run(1'b1, space_len(b));
    end
    if (nbytes >= MAX_BYTES) begin
      put_sample(1'b0);
    end else begin
      put_run(1'b0, mark_len());
      put_run(1'b1, stop_len());
    end
  endtask

  // marks too short for a leader
  task automatic send_noise();
    repeat ($urandom_range(1, 4)) begin
      put_run(1'b0, $urandom_range(1, detect_v - 1));
      put_run(1'b1, $urandom_range(1, 3));
    end
  endtask

  task automatic random_frame();
    int r, nb, tail;
    r    = $urandom_range(0, 99);
    nb   = (r < 15) ? 0 : $urandom_range(1, 2);
    tail = $urandom_range(0, 7);
    if (stop_v - adjust_v < 1) begin
      nb   = 0;
      tail = 0;
    end
    foreach (frame_bytes[i]) frame_bytes[i] = 8'($urandom);
    in_quiet = ($urandom_range(0, 3) == 0);
    if (detect_v >= 2 && $urandom_range(0, 4) == 0) send_noise();
    send_frame(detect_v + $urandom_range(0, 4), $urandom_range(1, 6), nb, tail);
  endtask

  task automatic random_regs();
    int det, adj, one;
    det = $urandom_range(0, 8);
    adj = $urandom_range(0, 3);
    one = $urandom_range(0, 6);
    set_regs(det, adj, one, one + $urandom_range(1, 6), $urandom_range(0, det + 6));
    mark_hi    = adj + 3;
    space_span = 8;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // zero detect, huge adjust: clamped marks, saturated spaces, immediate stop
    set_regs(0, 65535, 0, 65534, 65535);
    mark_hi    = 5;
    space_span = 4;
    in_quiet   = 1'b0;
    send_frame(0, 3, 0, 0);
    send_frame(5, 1, 0, 0);
    settle();

    // small timing, directed byte patterns
    set_regs(3, 1, 3, 7, 5);
    mark_hi    = 2;
    space_span = 3;
    frame_bytes[0] = 8'h00;
    send_frame(4, 2, 1, 0);
    frame_bytes[0] = 8'hFF;
    frame_bytes[1] = 8'hFE;
    send_frame(3, 1, 2, 3);
    send_noise();
    send_frame(4, 2, 0, 0);
    send_frame(9, 2, 0, 4);
    settle();

    // shortest bit cells: frame ends on a full store
    set_regs(1, 0, 1, 2, 3);
    mark_hi    = 1;
    space_span = 1;
    foreach (frame_bytes[i]) frame_bytes[i] = 8'($urandom);
    send_frame(2, 1, MAX_BYTES, 0);
    settle();

    sample_count = 0;
    while (sample_count < RANDOM_SAMPLES) begin
      random_regs();
      repeat ($urandom_range(1, 3)) random_frame();
      settle();
    end

    repeat (40) @(negedge clk);
    if (fail_count == 0 && pending == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/irpdd_pkg.sv
design/ir_pulse_distance_decoder.sv
design/irpdd_checker.sv
tb/sv/ir_frame_check.sv
tb/sv/tb_ir_pulse_distance_decoder.sv
